>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, operation codes, types and index helpers for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int FUNC_BITS = 3;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_PUSH_BACK  = 3'd0,
		FUNC_PUSH_FRONT = 3'd1,
		FUNC_POP_BACK   = 3'd2,
		FUNC_POP_FRONT  = 3'd3,
		FUNC_CLEAR      = 3'd4
	} deq_func_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} deq_state_t;

	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	// Access request from the sequencer to the ring store.
	typedef struct packed {
		logic  wr_en;
		idx_t  wr_addr;
		word_t wr_data;
		logic  rd_en;
		idx_t  rd_addr;
	} deq_store_req_t;

	function automatic idx_t idx_inc(idx_t i);
		idx_t r;
		if (i == IDX_BITS'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

	function automatic idx_t idx_dec(idx_t i);
		idx_t r;
		if (i == '0) begin
			r = IDX_BITS'(DEPTH - 1);
		end else begin
			r = i - 1'b1;
		end
		return r;
	endfunction

endpackage

>>> rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels of the double-ended queue: the operation request
// channel and the result channel.
// ----------------------------------------------------------------------------
interface deq_req_if;
	logic                           valid;
	logic                           ready;
	logic [deq_pkg::FUNC_BITS-1:0]  func;
	logic [deq_pkg::WORD_BITS-1:0]  push_word;

	modport source (output valid, output func, output push_word, input ready);
	modport sink   (input valid, input func, input push_word, output ready);
endinterface

interface deq_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [deq_pkg::WORD_BITS-1:0]  pop_word;
	logic                           pop_valid;
	logic [deq_pkg::WORD_BITS-1:0]  front_word;
	logic [deq_pkg::WORD_BITS-1:0]  back_word;
	logic [deq_pkg::CNT_BITS-1:0]   count;
	logic                           is_empty;
	logic                           is_full;
	logic                           push_rejected;

	modport source (output valid, output pop_word, output pop_valid, output front_word,
		output back_word, output count, output is_empty, output is_full,
		output push_rejected, input ready);
	modport sink   (input valid, input pop_word, input pop_valid, input front_word,
		input back_word, input count, input is_empty, input is_full,
		input push_rejected, output ready);
endinterface

>>> rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of data words held in a ring store.
// ----------------------------------------------------------------------------
// Usage:
// Each word on req carries an operation (push back, push front, pop back,
// pop front or clear) and a push word. Every accepted word yields exactly
// one word on rsp with the popped word, the front and back words, the count,
// empty, full and a push-rejected flag.
// The front and back words are cached in registers, so pushes, clears,
// pops on an empty queue and pops that empty the queue need no store read.
// A pop that leaves words behind reads the new end word from the store in
// the read state before its result is registered, so throughput is one word
// per cycle for pushes while rsp does not stall, and no new request is taken
// while such a pop waits for its read.
// The result sits in an output register; a new request is taken in the
// same cycle the pending result is taken, and req.ready stays low while
// rsp stalls.
// Reset empties the queue at once (no clearing pass); store contents are
// left undefined and are never reported.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	deq_req_if.sink     req,
	deq_rsp_if.source   rsp
);

	deq_pkg::deq_state_t     state_q, state_d;
	deq_pkg::idx_t           front_idx_q, front_idx_d;
	deq_pkg::idx_t           back_idx_q, back_idx_d;
	deq_pkg::cnt_t           occ_q, occ_d;
	deq_pkg::word_t          front_word_q, front_word_d;
	deq_pkg::word_t          back_word_q, back_word_d;
	deq_pkg::word_t          pop_word_q, pop_word_d;
	logic                    pop_valid_q, pop_valid_d;
	logic                    rejected_q, rejected_d;
	logic                    read_back_q, read_back_d;
	logic                    out_valid_q, out_valid_d;
	deq_pkg::deq_store_req_t store_req;
	deq_pkg::word_t          rd_data;
	deq_pkg::deq_func_t      func;
	deq_pkg::idx_t           nidx;
	logic                    accept;
	logic                    empty;
	logic                    full;

	deq_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (rd_data)
	);

	assign func   = deq_pkg::deq_func_t'(req.func);
	assign empty  = (occ_q == '0);
	assign full   = (occ_q == deq_pkg::CNT_BITS'(deq_pkg::DEPTH));
	assign req.ready = (state_q == deq_pkg::ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;

	always_comb begin
		state_d      = state_q;
		front_idx_d  = front_idx_q;
		back_idx_d   = back_idx_q;
		occ_d        = occ_q;
		front_word_d = front_word_q;
		back_word_d  = back_word_q;
		pop_word_d   = pop_word_q;
		pop_valid_d  = pop_valid_q;
		rejected_d   = rejected_q;
		read_back_d  = read_back_q;
		out_valid_d  = out_valid_q && !rsp.ready;
		store_req    = '0;
		nidx         = '0;

		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				if (accept) begin
					out_valid_d = 1'b1;
					pop_word_d  = '0;
					pop_valid_d = 1'b0;
					rejected_d  = 1'b0;
					unique case (func)
						deq_pkg::FUNC_PUSH_BACK: begin
							if (full) begin
								rejected_d = 1'b1;
							end else begin
								nidx              = deq_pkg::idx_inc(back_idx_q);
								store_req.wr_en   = 1'b1;
								store_req.wr_addr = nidx;
								store_req.wr_data = req.push_word;
								back_idx_d        = nidx;
								back_word_d       = req.push_word;
								if (empty) begin
									front_word_d = req.push_word;
								end
								occ_d = occ_q + 1'b1;
							end
						end
						deq_pkg::FUNC_PUSH_FRONT: begin
							if (full) begin
								rejected_d = 1'b1;
							end else begin
								nidx              = deq_pkg::idx_dec(front_idx_q);
								store_req.wr_en   = 1'b1;
								store_req.wr_addr = nidx;
								store_req.wr_data = req.push_word;
								front_idx_d       = nidx;
								front_word_d      = req.push_word;
								if (empty) begin
									back_word_d = req.push_word;
								end
								occ_d = occ_q + 1'b1;
							end
						end
						deq_pkg::FUNC_POP_BACK: begin
							if (!empty) begin
								nidx        = deq_pkg::idx_dec(back_idx_q);
								pop_word_d  = back_word_q;
								pop_valid_d = 1'b1;
								back_idx_d  = nidx;
								occ_d       = occ_q - 1'b1;
								// The new back word has to come from the store.
								if (occ_q != deq_pkg::CNT_BITS'(1)) begin
									store_req.rd_en   = 1'b1;
									store_req.rd_addr = nidx;
									read_back_d       = 1'b1;
									out_valid_d       = 1'b0;
									state_d           = deq_pkg::ST_READ;
								end
							end
						end
						deq_pkg::FUNC_POP_FRONT: begin
							if (!empty) begin
								nidx        = deq_pkg::idx_inc(front_idx_q);
								pop_word_d  = front_word_q;
								pop_valid_d = 1'b1;
								front_idx_d = nidx;
								occ_d       = occ_q - 1'b1;
								if (occ_q != deq_pkg::CNT_BITS'(1)) begin
									store_req.rd_en   = 1'b1;
									store_req.rd_addr = nidx;
									read_back_d       = 1'b0;
									out_valid_d       = 1'b0;
									state_d           = deq_pkg::ST_READ;
								end
							end
						end
						deq_pkg::FUNC_CLEAR: begin
							occ_d       = '0;
							front_idx_d = '0;
							back_idx_d  = deq_pkg::IDX_BITS'(deq_pkg::DEPTH - 1);
						end
						default: begin
						end
					endcase
				end
			end
			deq_pkg::ST_READ: begin
				if (read_back_q) begin
					back_word_d = rd_data;
				end else begin
					front_word_d = rd_data;
				end
				out_valid_d = 1'b1;
				state_d     = deq_pkg::ST_IDLE;
			end
			default: begin
				state_d = deq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::ST_IDLE;
			front_idx_q <= '0;
			back_idx_q  <= deq_pkg::IDX_BITS'(deq_pkg::DEPTH - 1);
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_idx_q <= front_idx_d;
			back_idx_q  <= back_idx_d;
			occ_q       <= occ_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		front_word_q <= front_word_d;
		back_word_q  <= back_word_d;
		pop_word_q   <= pop_word_d;
		pop_valid_q  <= pop_valid_d;
		rejected_q   <= rejected_d;
		read_back_q  <= read_back_d;
	end

	// The occupancy only moves when a new request is taken, which is also the
	// edge at which the pending result leaves, so status can come from it.
	assign rsp.valid         = out_valid_q;
	assign rsp.pop_word      = pop_word_q;
	assign rsp.pop_valid     = pop_valid_q;
	assign rsp.front_word    = empty ? '0 : front_word_q;
	assign rsp.back_word     = empty ? '0 : back_word_q;
	assign rsp.count         = occ_q;
	assign rsp.is_empty      = empty;
	assign rsp.is_full       = full;
	assign rsp.push_rejected = rejected_q;

endmodule

>>> rtl/deq_store.sv
// ----------------------------------------------------------------------------
// deq_store
// Ring store of the queue: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module deq_store (
	input  logic                     clk,
	input  deq_pkg::deq_store_req_t  req,
	output deq_pkg::word_t           rd_data
);

	deq_pkg::word_t ring_q [deq_pkg::DEPTH];
	deq_pkg::word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			ring_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= ring_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
